// ===== src/lru_pkg.sv =====
// Shared types and sizes for the LRU replacement tracker.
// No dependencies; used by the front queue, the back engine and the top level.
`default_nettype none
package lru_pkg;

  localparam int NumSlots = 16;
  localparam int IdWidth  = 32;
  localparam int SlotW    = $clog2(NumSlots);
  localparam int CntW     = $clog2(NumSlots + 1);
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [0:0] {
    REQ_ACCESS = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef struct packed {
    req_e               req;
    logic [IdWidth-1:0] id;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [IdWidth-1:0] evicted_id;
    logic               not_found;
    logic [CntW-1:0]    occupancy;
  } result_t;

endpackage
`default_nettype wire

// ===== src/lru_replacement_tracker.sv =====
// Top level of the LRU replacement tracker: capacity register, front queue
// and back engine. Depends on lru_pkg, lru_front and lru_back.
//
// Usage:
//   Requests: drive req_type_i and obj_id_i with start high; the item is taken
//   at a rising edge where start is high and busy is low. busy rises only when
//   the two-entry request queue is full.
//   Results: one per item, in order, on the result ports for one cycle with
//   done_o high. The receiver cannot stall; results are never held back.
//   Timing: with the queue empty, an accepted item passes the queue entry, the
//   back engine's compare phase and then its rank update phase before its result
//   shows. The back engine takes no new item until that update phase has ended.
//   Configuration: cfg_data_i is written to the capacity register at an edge
//   with cfg_valid_i and cfg_ready_o high; cfg_ready_o is always high. Write
//   only while the block is idle. Capacity zero acts as one, above 16 as 16.
//   Reset: all entries invalid, occupancy zero, capacity 16, queue empty.
`default_nettype none
module lru_replacement_tracker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type_i,
  input  wire logic [lru_pkg::IdWidth-1:0]   obj_id_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lru_pkg::CntW-1:0]      cfg_data_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic                               evicted_o,
  output logic [lru_pkg::IdWidth-1:0]        evicted_id_o,
  output logic                               not_found_o,
  output logic [lru_pkg::CntW-1:0]           occupancy_o
);

  logic [lru_pkg::CntW-1:0] capacity_q;
  logic                     full, nonempty, pop;
  lru_pkg::item_t           head;
  lru_pkg::result_t         result;

  assign cfg_ready_o = 1'b1;
  assign busy        = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= lru_pkg::CntW'(lru_pkg::NumSlots);
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  lru_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (start),
    .req_i      (lru_pkg::req_e'(req_type_i)),
    .id_i       (obj_id_i),
    .full_o     (full),
    .nonempty_o (nonempty),
    .head_o     (head),
    .pop_i      (pop)
  );

  lru_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (nonempty),
    .item_i     (head),
    .pop_o      (pop),
    .capacity_i (capacity_q),
    .done_o     (done_o),
    .result_o   (result)
  );

  assign hit_o        = result.hit;
  assign evicted_o    = result.evicted;
  assign evicted_id_o = result.evicted_id;
  assign not_found_o  = result.not_found;
  assign occupancy_o  = result.occupancy;

endmodule
`default_nettype wire

// ===== src/lru_front.sv =====
// Front of the LRU tracker: accepts items and holds them in a short queue.
// Depends on lru_pkg.
`default_nettype none
module lru_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lru_pkg::req_e req_i,
  input  wire logic [lru_pkg::IdWidth-1:0] id_i,
  output logic               full_o,
  output logic               nonempty_o,
  output lru_pkg::item_t     head_o,
  input  wire logic          pop_i
);

  lru_pkg::item_t                 entries_q [lru_pkg::QDepth];
  logic [lru_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [lru_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o     = (cnt_q == lru_pkg::QCntW'(lru_pkg::QDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = entries_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= '{req: req_i, id: id_i};
    end
  end

endmodule
`default_nettype wire

// ===== src/lru_back.sv =====
// Back of the LRU tracker: compares against held ids, then updates ranks.
// Two phases per item: compare and classify, then update and report.
// Depends on lru_pkg.
`default_nettype none
module lru_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      avail_i,
  input  wire lru_pkg::item_t            item_i,
  output logic                           pop_o,
  input  wire logic [lru_pkg::CntW-1:0]  capacity_i,
  output logic                           done_o,
  output lru_pkg::result_t               result_o
);

  localparam int N  = lru_pkg::NumSlots;
  localparam int SW = lru_pkg::SlotW;
  localparam int CW = lru_pkg::CntW;

  localparam logic PH_CMP = 1'b0;
  localparam logic PH_UPD = 1'b1;

  logic [lru_pkg::IdWidth-1:0] ids_q [N];
  logic [N-1:0]                valid_q, valid_d;
  logic [SW-1:0]               rank_q [N];
  logic [SW-1:0]               rank_d [N];
  logic [CW-1:0]               count_q, count_d;
  logic                        phase_q;

  lru_pkg::item_t              item_q;
  logic                        hit_q, evict_q, f_ok_q;
  logic [SW-1:0]               m_idx_q, m_rank_q, v_idx_q, f_idx_q;

  logic                        done_q;
  lru_pkg::result_t            res_q;

  logic [N-1:0]                match_vec, old_vec;
  logic [SW-1:0]               m_idx, v_idx, f_idx;
  logic                        f_ok;
  logic [CW-1:0]               eff_cap;
  logic                        evict_c;

  logic [SW-1:0]               ins_idx;
  logic                        ins_ok, ins_en;
  logic                        acc_q, rem_q;

  always_comb begin
    m_idx = '0;
    v_idx = '0;
    f_idx = '0;
    f_ok  = 1'b0;
    for (int i = 0; i < N; i++) begin
      match_vec[i] = valid_q[i] && (ids_q[i] == item_i.id);
      old_vec[i]   = valid_q[i] && ({1'b0, rank_q[i]} == (count_q - 1'b1));
      if (match_vec[i]) begin
        m_idx = m_idx | SW'(i);
      end
      if (old_vec[i]) begin
        v_idx = v_idx | SW'(i);
      end
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        f_idx = SW'(i);
        f_ok  = 1'b1;
      end
    end
  end

  always_comb begin
    if (capacity_i == '0) begin
      eff_cap = CW'(1);
    end else if (capacity_i > CW'(N)) begin
      eff_cap = CW'(N);
    end else begin
      eff_cap = capacity_i;
    end
  end

  assign evict_c = (item_i.req == lru_pkg::REQ_ACCESS) && !(|match_vec) &&
                   (count_q != '0) &&
                   (({1'b0, count_q} + (CW+1)'(1)) > {1'b0, eff_cap});

  assign pop_o = (phase_q == PH_CMP) && avail_i;

  assign acc_q   = (item_q.req == lru_pkg::REQ_ACCESS);
  assign rem_q   = (item_q.req == lru_pkg::REQ_REMOVE);
  assign ins_idx = (evict_q && (!f_ok_q || (v_idx_q < f_idx_q))) ? v_idx_q : f_idx_q;
  assign ins_ok  = evict_q || f_ok_q;
  assign ins_en  = (phase_q == PH_UPD) && acc_q && !hit_q && ins_ok;

  always_comb begin
    logic va;
    va      = 1'b0;
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < N; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (acc_q) begin
      if (hit_q) begin
        for (int i = 0; i < N; i++) begin
          if (SW'(i) == m_idx_q) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < m_rank_q)) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < N; i++) begin
          va = valid_q[i] && !(evict_q && (SW'(i) == v_idx_q));
          if (ins_ok && (SW'(i) == ins_idx)) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (!va) begin
            valid_d[i] = 1'b0;
            rank_d[i]  = va ? rank_q[i] : (valid_q[i] ? '0 : rank_q[i]);
          end else if (ins_ok) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        count_d = count_q - CW'(evict_q) + CW'(ins_ok);
      end
    end else if (hit_q) begin
      for (int i = 0; i < N; i++) begin
        if (SW'(i) == m_idx_q) begin
          valid_d[i] = 1'b0;
          rank_d[i]  = '0;
        end else if (valid_q[i] && (rank_q[i] > m_rank_q)) begin
          rank_d[i] = rank_q[i] - 1'b1;
        end
      end
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMP;
      done_q  <= 1'b0;
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        PH_CMP: begin
          if (avail_i) begin
            phase_q <= PH_UPD;
          end
        end
        PH_UPD: begin
          phase_q <= PH_CMP;
          done_q  <= 1'b1;
          valid_q <= valid_d;
          count_q <= count_d;
          for (int i = 0; i < N; i++) begin
            rank_q[i] <= rank_d[i];
          end
        end
        default: begin
          phase_q <= PH_CMP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q   <= item_i;
      hit_q    <= |match_vec;
      evict_q  <= evict_c;
      m_idx_q  <= m_idx;
      m_rank_q <= rank_q[m_idx];
      v_idx_q  <= v_idx;
      f_idx_q  <= f_idx;
      f_ok_q   <= f_ok;
    end
    if (ins_en) begin
      ids_q[ins_idx] <= item_q.id;
    end
    if (phase_q == PH_UPD) begin
      res_q.hit        <= hit_q;
      res_q.evicted    <= acc_q && evict_q && !hit_q;
      res_q.evicted_id <= (acc_q && evict_q && !hit_q) ? ids_q[v_idx_q] : '0;
      res_q.not_found  <= rem_q && !hit_q;
      res_q.occupancy  <= count_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// ===== dv/lru_replacement_tracker_test.sv =====
// Testbench for lru_replacement_tracker: directed and random access/remove traffic
// across several capacity settings, checked result by result against an in-bench LRU model.
// Depends on lru_pkg and the lru_replacement_tracker RTL.
module lru_replacement_tracker_test;

  localparam int IdWidth  = lru_pkg::IdWidth;
  localparam int CntW     = lru_pkg::CntW;
  localparam int NumSlots = lru_pkg::NumSlots;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                req_type_i  = 1'b0;
  logic [IdWidth-1:0]  obj_id_i    = '0;
  logic                cfg_valid_i = 1'b0;
  logic [CntW-1:0]     cfg_data_i  = '0;
  logic                busy;
  logic                cfg_ready_o;
  logic                done_o;
  logic                hit_o;
  logic                evicted_o;
  logic [IdWidth-1:0]  evicted_id_o;
  logic                not_found_o;
  logic [CntW-1:0]     occupancy_o;

  lru_replacement_tracker u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .obj_id_i     (obj_id_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .evicted_o    (evicted_o),
    .evicted_id_o (evicted_id_o),
    .not_found_o  (not_found_o),
    .occupancy_o  (occupancy_o)
  );

  logic [IdWidth-1:0] slot_id   [NumSlots];
  bit                 slot_live [NumSlots];
  int unsigned        slot_age  [NumSlots];
  int unsigned        live_count   = 0;
  logic [CntW-1:0]    capacity_reg = CntW'(16);

  lru_pkg::result_t   pending_results [$];
  int                 errors       = 0;
  int                 n_items      = 0;
  int                 n_results    = 0;
  int                 n_hits       = 0;
  int                 n_evictions  = 0;
  int                 n_absent     = 0;
  int                 n_cap_writes = 0;
  bit                 steady       = 1'b0;
  logic [IdWidth-1:0] id_pool [$];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned effective_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > NumSlots) return NumSlots;
    return capacity_reg;
  endfunction

  function automatic void drop_entry(int s);
    int unsigned age;
    age = slot_age[s];
    slot_live[s] = 1'b0;
    slot_age[s] = 0;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_live[i] && slot_age[i] > age) slot_age[i]--;
    end
    if (live_count > 0) live_count--;
  endfunction

  function automatic lru_pkg::result_t lru_predict(lru_pkg::req_e req,
                                                   logic [IdWidth-1:0] id);
    lru_pkg::result_t r;
    int               found;
    int               victim;
    int               free_slot;
    int unsigned      age;
    r = '0;
    found = -1;
    for (int i = 0; i < NumSlots; i++) begin
      if (found < 0 && slot_live[i] && slot_id[i] == id) found = i;
    end
    if (req == lru_pkg::REQ_ACCESS) begin
      if (found >= 0) begin
        r.hit = 1'b1;
        age = slot_age[found];
        for (int i = 0; i < NumSlots; i++) begin
          if (slot_live[i] && slot_age[i] < age) slot_age[i]++;
        end
        slot_age[found] = 0;
      end else begin
        if (live_count > 0 && live_count + 1 > effective_capacity()) begin
          victim = -1;
          for (int i = 0; i < NumSlots; i++) begin
            if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
          end
          if (victim >= 0) begin
            r.evicted = 1'b1;
            r.evicted_id = slot_id[victim];
            drop_entry(victim);
          end
        end
        free_slot = -1;
        for (int i = 0; i < NumSlots; i++) begin
          if (free_slot < 0 && !slot_live[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < NumSlots; i++) begin
            if (slot_live[i]) slot_age[i]++;
          end
          slot_id[free_slot] = id;
          slot_live[free_slot] = 1'b1;
          slot_age[free_slot] = 0;
          live_count++;
        end
      end
    end else begin
      if (found >= 0) begin
        r.hit = 1'b1;
        drop_entry(found);
      end else begin
        r.not_found = 1'b1;
      end
    end
    r.occupancy = CntW'(live_count);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 20) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    lru_pkg::result_t got;
    lru_pkg::result_t want;
    if (rst_ni && done_o === 1'b1) begin
      got.hit        = hit_o;
      got.evicted    = evicted_o;
      got.evicted_id = evicted_id_o;
      got.not_found  = not_found_o;
      got.occupancy  = occupancy_o;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (want.hit) n_hits++;
        if (want.evicted) n_evictions++;
        if (want.not_found) n_absent++;
        if (got.hit !== want.hit)
          report_mismatch($sformatf("result %0d hit %b, want %b", n_results, got.hit, want.hit));
        if (got.evicted !== want.evicted)
          report_mismatch($sformatf("result %0d evicted %b, want %b",
                                    n_results, got.evicted, want.evicted));
        if (got.evicted_id !== want.evicted_id)
          report_mismatch($sformatf("result %0d evicted_id %h, want %h",
                                    n_results, got.evicted_id, want.evicted_id));
        if (got.not_found !== want.not_found)
          report_mismatch($sformatf("result %0d not_found %b, want %b",
                                    n_results, got.not_found, want.not_found));
        if (got.occupancy !== want.occupancy)
          report_mismatch($sformatf("result %0d occupancy %0d, want %0d",
                                    n_results, got.occupancy, want.occupancy));
      end
    end
  end

  task automatic issue_item(lru_pkg::req_e req, logic [IdWidth-1:0] id);
    int g;
    int r;
    start      <= 1'b1;
    req_type_i <= req;
    obj_id_i   <= id;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(lru_predict(req, id));
    n_items++;
    r = $urandom_range(0, 99);
    if (steady) g = 0;
    else if (r < 55) g = 0;
    else if (r < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(8, 40);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CntW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    capacity_reg = v;
    n_cap_writes++;
  endtask

  task automatic test_basic_ops();
    issue_item(lru_pkg::REQ_ACCESS, 32'h0000_0000);
    issue_item(lru_pkg::REQ_ACCESS, 32'hFFFF_FFFF);
    issue_item(lru_pkg::REQ_ACCESS, 32'h0000_0000);
    issue_item(lru_pkg::REQ_REMOVE, 32'h0000_0005);
    issue_item(lru_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
    issue_item(lru_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
    issue_item(lru_pkg::REQ_REMOVE, 32'h0000_0000);
    issue_item(lru_pkg::REQ_REMOVE, 32'h0000_0000);
    wait_idle();
  endtask

  task automatic test_capacity_extremes();
    set_capacity(CntW'(2));
    issue_item(lru_pkg::REQ_ACCESS, 32'd1);
    issue_item(lru_pkg::REQ_ACCESS, 32'd2);
    issue_item(lru_pkg::REQ_ACCESS, 32'd3);
    issue_item(lru_pkg::REQ_ACCESS, 32'd2);
    issue_item(lru_pkg::REQ_ACCESS, 32'd4);
    wait_idle();
    set_capacity(CntW'(0));
    issue_item(lru_pkg::REQ_ACCESS, 32'd7);
    issue_item(lru_pkg::REQ_ACCESS, 32'd8);
    wait_idle();
    set_capacity(CntW'(31));
    issue_item(lru_pkg::REQ_ACCESS, 32'd9);
    wait_idle();
  endtask

  task automatic test_capacity_shrink();
    set_capacity(CntW'(1));
    issue_item(lru_pkg::REQ_ACCESS, 32'd7);
    issue_item(lru_pkg::REQ_ACCESS, 32'd10);
    issue_item(lru_pkg::REQ_REMOVE, 32'd9);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [CntW-1:0]    caps [8];
    logic [IdWidth-1:0] id;
    int                 r;
    caps = '{CntW'(16), CntW'(1), CntW'(31), CntW'(0), CntW'(17), CntW'(5),
             CntW'($urandom_range(0, 31)), CntW'($urandom_range(0, 31))};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      id_pool.delete();
      repeat (effective_capacity() + $urandom_range(1, 8)) id_pool.push_back($urandom);
      for (int n = 0; n < 170; n++) begin
        if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 80) id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else id = $urandom;
        if (r < 70 || (r >= 80 && r < 90)) issue_item(lru_pkg::REQ_ACCESS, id);
        else issue_item(lru_pkg::REQ_REMOVE, id);
      end
      steady = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_capacity_extremes();
    test_capacity_shrink();
    test_random_traffic();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d items over %0d capacity settings, saturating ones included.",
             n_items, n_cap_writes);
    $display("Saw %0d hits, %0d evictions and %0d removes of absent ids; %0d errors.",
             n_hits, n_evictions, n_absent, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
